FILE: rtl/core/vtpd_pkg.sv
// vtpd_pkg: shared constants, types and reset values of the vertex transform core
// no dependencies
`default_nettype none

package vtpd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 64;
  localparam int NREG      = 8;
  localparam int IDX_W     = 4;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RS_W      = SUM_W - FRAC_BITS;
  localparam int QB        = DATA_W + 1;
  localparam int NUM_W     = RS_W + FRAC_BITS;
  localparam int REM_W     = RS_W + 1;
  localparam int LAT       = QB + 6;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [RS_W-1:0]   rsum_t;

  localparam fix_t ONE_Q   = fix_t'(1) <<< FRAC_BITS;
  localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    ACT_POINT  = 1'b0,
    ACT_VECTOR = 1'b1
  } action_e;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_A = 4'd0,
    REG_ROW0_B = 4'd1,
    REG_ROW1_A = 4'd2,
    REG_ROW1_B = 4'd3,
    REG_ROW2_A = 4'd4,
    REG_ROW2_B = 4'd5,
    REG_ROW3_A = 4'd6,
    REG_ROW3_B = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic           vec;
    fix_t [3:0]     vres;
    logic           vsat;
    logic [2:0]     neg;
  } side_t;

  // identity matrix
  function automatic logic [CFG_W-1:0] cfg_reset(input int idx);
    logic [CFG_W-1:0] one_lo;
    one_lo = CFG_W'(unsigned'(ONE_Q));
    case (idx)
      int'(REG_ROW0_A): cfg_reset = one_lo;
      int'(REG_ROW1_A): cfg_reset = one_lo << DATA_W;
      int'(REG_ROW2_B): cfg_reset = one_lo;
      int'(REG_ROW3_B): cfg_reset = one_lo << DATA_W;
      default:          cfg_reset = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vtpd_if.sv
// vtpd channel interfaces: vertex request, result request, configuration write
// depends on vtpd_pkg
`default_nettype none

interface vtpd_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  vtpd_pkg::fix_t      in_x;
  vtpd_pkg::fix_t      in_y;
  vtpd_pkg::fix_t      in_z;
  vtpd_pkg::fix_t      in_w;
  modport source (output valid, action, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, action, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtpd_out_if;
  logic                valid;
  logic                ready;
  vtpd_pkg::fix_t      out_x;
  vtpd_pkg::fix_t      out_y;
  vtpd_pkg::fix_t      out_z;
  vtpd_pkg::fix_t      out_w;
  logic                saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

interface vtpd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vtpd_pkg::IDX_W-1:0]        index;
  logic [vtpd_pkg::CFG_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/vtpd_row.sv
// vtpd_row: one matrix row, four products, pairwise sums, rounded row sum
// three register stages; depends on vtpd_pkg
`default_nettype none

module vtpd_row (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire vtpd_pkg::fix_t [3:0]  coef_i,
  input  wire vtpd_pkg::fix_t [3:0]  vec_i,
  output vtpd_pkg::rsum_t            sum_o
);

  localparam logic signed [vtpd_pkg::SUM_W-1:0] HALF =
    vtpd_pkg::SUM_W'(1) <<< (vtpd_pkg::FRAC_BITS - 1);

  logic signed [vtpd_pkg::PROD_W-1:0] prod_q [4];
  logic signed [vtpd_pkg::PAIR_W-1:0] pair_q [2];
  logic signed [vtpd_pkg::SUM_W-1:0]  sum_d;
  vtpd_pkg::rsum_t                    sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c] <= vtpd_pkg::PROD_W'(coef_i[c]) * vtpd_pkg::PROD_W'(vec_i[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_q[0] <= vtpd_pkg::PAIR_W'(prod_q[0]) + vtpd_pkg::PAIR_W'(prod_q[1]);
      pair_q[1] <= vtpd_pkg::PAIR_W'(prod_q[2]) + vtpd_pkg::PAIR_W'(prod_q[3]);
    end
  end

  // round half up
  assign sum_d = vtpd_pkg::SUM_W'(pair_q[0]) + vtpd_pkg::SUM_W'(pair_q[1]) + HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d[vtpd_pkg::SUM_W-1:vtpd_pkg::FRAC_BITS];
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

FILE: rtl/core/vtpd_div.sv
// vtpd_div: pipelined restoring divider, one quotient bit per stage
// flags quotients that do not fit in QB bits; depends on vtpd_pkg
`default_nettype none

module vtpd_div (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [vtpd_pkg::NUM_W-1:0]    num_i,
  input  wire logic [vtpd_pkg::RS_W-1:0]     den_i,
  output logic [vtpd_pkg::QB-1:0]            q_o,
  output logic                               big_o
);

  localparam int QB = vtpd_pkg::QB;

  logic [vtpd_pkg::REM_W-1:0] rem_s [QB+1];
  logic [vtpd_pkg::NUM_W-1:0] num_s [QB+1];
  logic [vtpd_pkg::RS_W-1:0]  den_s [QB+1];
  logic [QB-1:0]              q_s   [QB+1];
  logic                       big_s [QB+1];

  assign rem_s[0] = vtpd_pkg::REM_W'(num_i >> QB);
  assign num_s[0] = num_i;
  assign den_s[0] = den_i;
  assign q_s[0]   = '0;
  assign big_s[0] = vtpd_pkg::REM_W'(num_i >> QB) >= vtpd_pkg::REM_W'(den_i);

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [vtpd_pkg::REM_W-1:0] trial;
    logic                       ge;
    logic [vtpd_pkg::REM_W-1:0] rem_q;
    logic [vtpd_pkg::NUM_W-1:0] num_q;
    logic [vtpd_pkg::RS_W-1:0]  den_q;
    logic [QB-1:0]              q_q;
    logic                       big_q;

    assign trial = {rem_s[k][vtpd_pkg::REM_W-2:0], num_s[k][QB-1-k]};
    assign ge    = trial >= vtpd_pkg::REM_W'(den_s[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? trial - vtpd_pkg::REM_W'(den_s[k]) : trial;
        num_q <= num_s[k];
        den_q <= den_s[k];
        q_q   <= {q_s[k][QB-2:0], ge};
        big_q <= big_s[k];
      end
    end

    assign rem_s[k+1] = rem_q;
    assign num_s[k+1] = num_q;
    assign den_s[k+1] = den_q;
    assign q_s[k+1]   = q_q;
    assign big_s[k+1] = big_q;
  end

  assign q_o   = q_s[QB];
  assign big_o = big_s[QB];

endmodule

`default_nettype wire

FILE: rtl/core/vertex_transform_perspective_divide_core.sv
// Vertex transform core: 4x4 fixed-point matrix times vertex, optional perspective divide.
// One vertex per cycle while the output is not stalled. Stages: the input register, the product,
// pairwise sum and rounded sum registers of the rows, one prep stage, one stage per quotient bit
// of the divider, one output register. A stall at the output freezes the whole pipeline.
// Depends on vtpd_pkg, vtpd_if, vtpd_row, vtpd_div.
`default_nettype none

module vertex_transform_perspective_divide_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vtpd_in_if.sink    vtx_in,
  vtpd_out_if.source vtx_out,
  vtpd_cfg_if.sink   cfg_wr
);

  localparam int QB  = vtpd_pkg::QB;
  localparam int LAT = vtpd_pkg::LAT;

  logic [vtpd_pkg::CFG_W-1:0] cfg_q [vtpd_pkg::NREG];
  logic                       en;
  logic [LAT-1:0]             valid_q;

  // configuration
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vtpd_pkg::NREG; i++) begin
        cfg_q[i] <= vtpd_pkg::cfg_reset(i);
      end
    end else if (cfg_wr.valid) begin
      case (vtpd_pkg::reg_idx_e'(cfg_wr.index))
        vtpd_pkg::REG_ROW0_A: cfg_q[0] <= cfg_wr.data;
        vtpd_pkg::REG_ROW0_B: cfg_q[1] <= cfg_wr.data;
        vtpd_pkg::REG_ROW1_A: cfg_q[2] <= cfg_wr.data;
        vtpd_pkg::REG_ROW1_B: cfg_q[3] <= cfg_wr.data;
        vtpd_pkg::REG_ROW2_A: cfg_q[4] <= cfg_wr.data;
        vtpd_pkg::REG_ROW2_B: cfg_q[5] <= cfg_wr.data;
        vtpd_pkg::REG_ROW3_A: cfg_q[6] <= cfg_wr.data;
        vtpd_pkg::REG_ROW3_B: cfg_q[7] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // flow control
  assign en           = !valid_q[LAT-1] || vtx_out.ready;
  assign vtx_in.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], vtx_in.valid};
    end
  end

  // input stage
  vtpd_pkg::fix_t [3:0] vin_q;
  logic [4:1]           vec_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vin_q[0] <= vtx_in.in_x;
      vin_q[1] <= vtx_in.in_y;
      vin_q[2] <= vtx_in.in_z;
      vin_q[3] <= (vtx_in.action == vtpd_pkg::ACT_VECTOR) ? vtx_in.in_w : vtpd_pkg::ONE_Q;
      vec_q    <= {vec_q[3:1], vtx_in.action == vtpd_pkg::ACT_VECTOR};
    end
  end

  // row sums
  vtpd_pkg::rsum_t rs [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    vtpd_pkg::fix_t [3:0] coef;
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign coef[c] = cfg_q[r*2 + c/2][(c%2)*vtpd_pkg::DATA_W +: vtpd_pkg::DATA_W];
    end
    vtpd_row u_row (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef),
      .vec_i  (vin_q),
      .sum_o  (rs[r])
    );
  end

  // divide prep and vector clamp
  vtpd_pkg::rsum_t                w_div;
  logic [vtpd_pkg::RS_W-1:0]      den_d;
  logic [vtpd_pkg::NUM_W-1:0]     num_d [3];
  logic [vtpd_pkg::NUM_W-1:0]     num_q [3];
  logic [vtpd_pkg::RS_W-1:0]      den_q;
  vtpd_pkg::side_t                side_d;
  vtpd_pkg::side_t                side_q [QB+1];

  always_comb begin
    w_div = (rs[3] == '0) ? vtpd_pkg::RS_W'(vtpd_pkg::ONE_Q) : rs[3];
    den_d = w_div[vtpd_pkg::RS_W-1] ? vtpd_pkg::RS_W'(-w_div) : vtpd_pkg::RS_W'(w_div);
    side_d.vec  = vec_q[4];
    side_d.vsat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      if (rs[r] > vtpd_pkg::RS_W'(vtpd_pkg::FIX_MAX)) begin
        side_d.vres[r] = vtpd_pkg::FIX_MAX;
        side_d.vsat    = 1'b1;
      end else if (rs[r] < vtpd_pkg::RS_W'(vtpd_pkg::FIX_MIN)) begin
        side_d.vres[r] = vtpd_pkg::FIX_MIN;
        side_d.vsat    = 1'b1;
      end else begin
        side_d.vres[r] = rs[r][vtpd_pkg::DATA_W-1:0];
      end
    end
    for (int r = 0; r < 3; r++) begin
      side_d.neg[r] = rs[r][vtpd_pkg::RS_W-1] != w_div[vtpd_pkg::RS_W-1];
      num_d[r] = vtpd_pkg::NUM_W'(rs[r][vtpd_pkg::RS_W-1] ? vtpd_pkg::RS_W'(-rs[r])
                                                          : vtpd_pkg::RS_W'(rs[r]))
                 << vtpd_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q     <= num_d;
      den_q     <= den_d;
      side_q[0] <= side_d;
      for (int k = 1; k <= QB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // dividers
  logic [QB-1:0] quo [3];
  logic          big [3];

  for (genvar r = 0; r < 3; r++) begin : g_div
    vtpd_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[r]),
      .den_i (den_q),
      .q_o   (quo[r]),
      .big_o (big[r])
    );
  end

  // sign, saturation, output register
  vtpd_pkg::side_t      side_o;
  vtpd_pkg::fix_t [3:0] res_d;
  logic                 sat_d;
  vtpd_pkg::fix_t [3:0] res_q;
  logic                 sat_q;

  assign side_o = side_q[QB];

  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (side_o.neg[r]) begin
        if (big[r] || quo[r] > QB'(unsigned'(vtpd_pkg::FIX_MIN))) begin
          res_d[r] = vtpd_pkg::FIX_MIN;
          sat_d    = 1'b1;
        end else begin
          res_d[r] = vtpd_pkg::DATA_W'(-quo[r]);
        end
      end else if (big[r] || quo[r] > QB'(unsigned'(vtpd_pkg::FIX_MAX))) begin
        res_d[r] = vtpd_pkg::FIX_MAX;
        sat_d    = 1'b1;
      end else begin
        res_d[r] = vtpd_pkg::DATA_W'(quo[r]);
      end
    end
    res_d[3] = vtpd_pkg::ONE_Q;
    if (side_o.vec) begin
      res_d = side_o.vres;
      sat_d = side_o.vsat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign vtx_out.valid     = valid_q[LAT-1];
  assign vtx_out.out_x     = res_q[0];
  assign vtx_out.out_y     = res_q[1];
  assign vtx_out.out_z     = res_q[2];
  assign vtx_out.out_w     = res_q[3];
  assign vtx_out.saturated = sat_q;

endmodule

`default_nettype wire

FILE: rtl/core/vtpd_checker.sv
// vtpd_checker: port-level assertions on the vertex transform core, bound to the top level
// depends on vtpd_pkg and vertex_transform_perspective_divide_core
`default_nettype none

module vtpd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire vtpd_pkg::fix_t out_x,
  input wire vtpd_pkg::fix_t out_y,
  input wire vtpd_pkg::fix_t out_z,
  input wire vtpd_pkg::fix_t out_w,
  input wire logic           saturated
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
                                && $stable(out_w) && $stable(saturated))
    else $error("result payload changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |->
      out_x == vtpd_pkg::FIX_MAX || out_x == vtpd_pkg::FIX_MIN ||
      out_y == vtpd_pkg::FIX_MAX || out_y == vtpd_pkg::FIX_MIN ||
      out_z == vtpd_pkg::FIX_MAX || out_z == vtpd_pkg::FIX_MIN ||
      out_w == vtpd_pkg::FIX_MAX || out_w == vtpd_pkg::FIX_MIN)
    else $error("saturated flag without a clamped component");

endmodule

bind vertex_transform_perspective_divide_core vtpd_checker u_vtpd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (vtx_in.ready),
  .out_valid (vtx_out.valid),
  .out_ready (vtx_out.ready),
  .out_x     (vtx_out.out_x),
  .out_y     (vtx_out.out_y),
  .out_z     (vtx_out.out_z),
  .out_w     (vtx_out.out_w),
  .saturated (vtx_out.saturated)
);

`default_nettype wire

FILE: tb/sv/vtpd_tb_checker.sv
// vtpd_tb_checker: watches the vertex, result and configuration channels of the core,
// predicts every result from its own copy of the matrix and compares in order
// depends on vtpd_pkg and vtpd_if
`timescale 1ns / 1ps

module vtpd_tb_checker
  import vtpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  vtpd_in_if       vin,
  vtpd_out_if      vout,
  vtpd_cfg_if      vcfg,
  output int       fail_count_o,
  output int       pending_o
);

  typedef logic signed [SUM_W:0] acc_t;
  typedef logic signed [97:0]    quo_t;

  typedef struct {
    fix_t x, y, z, w;
    logic sat;
  } vertex_res_t;

  fix_t        mtx [4][4];
  vertex_res_t expected_q[$];
  int          fails;
  int          pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, exp);
    fails++;
  endtask

  function automatic acc_t rounded_row(input int r, input fix_t v[4]);
    acc_t acc;
    acc = '0;
    for (int c = 0; c < 4; c++) acc = acc + acc_t'(mtx[r][c]) * acc_t'(v[c]);
    rounded_row = (acc + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic fix_t clamp_fix(input quo_t val, inout logic sat);
    if (val > quo_t'(FIX_MAX)) begin
      sat = 1'b1;
      clamp_fix = FIX_MAX;
    end else if (val < quo_t'(FIX_MIN)) begin
      sat = 1'b1;
      clamp_fix = FIX_MIN;
    end else begin
      clamp_fix = fix_t'(val);
    end
  endfunction

  function automatic vertex_res_t transform_vertex(input logic act, input fix_t x, input fix_t y,
                                                   input fix_t z, input fix_t w);
    vertex_res_t res;
    fix_t        v[4];
    fix_t        o[4];
    quo_t        den;
    logic        sat;
    sat  = 1'b0;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = (act == ACT_VECTOR) ? w : ONE_Q;
    if (act == ACT_VECTOR) begin
      for (int r = 0; r < 4; r++) o[r] = clamp_fix(quo_t'(rounded_row(r, v)), sat);
    end else begin
      den = quo_t'(rounded_row(3, v));
      if (den == 0) den = quo_t'(ONE_Q);
      for (int r = 0; r < 3; r++)
        o[r] = clamp_fix((quo_t'(rounded_row(r, v)) <<< FRAC_BITS) / den, sat);
      o[3] = ONE_Q;
    end
    res.x   = o[0];
    res.y   = o[1];
    res.z   = o[2];
    res.w   = o[3];
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_res_t exp_res;
    int          row;
    int          col;
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) begin
        mtx[i / 2][2 * (i % 2)]     = fix_t'(cfg_reset(i));
        mtx[i / 2][2 * (i % 2) + 1] = fix_t'(cfg_reset(i) >> DATA_W);
      end
      expected_q.delete();
    end else begin
      if (vout.valid && vout.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t result request with no vertex outstanding", $realtime);
          fails++;
        end else begin
          exp_res = expected_q.pop_front();
          if (vout.out_x !== exp_res.x) report_mismatch("out_x", vout.out_x, exp_res.x);
          if (vout.out_y !== exp_res.y) report_mismatch("out_y", vout.out_y, exp_res.y);
          if (vout.out_z !== exp_res.z) report_mismatch("out_z", vout.out_z, exp_res.z);
          if (vout.out_w !== exp_res.w) report_mismatch("out_w", vout.out_w, exp_res.w);
          if (vout.saturated !== exp_res.sat)
            report_mismatch("saturated", 32'(vout.saturated), 32'(exp_res.sat));
        end
      end
      if (vin.valid && vin.ready)
        expected_q.push_back(transform_vertex(vin.action, vin.in_x, vin.in_y, vin.in_z,
                                              vin.in_w));
      if (vcfg.valid && vcfg.ready && vcfg.index < NREG) begin
        row = vcfg.index / 2;
        col = 2 * (vcfg.index % 2);
        mtx[row][col]     = fix_t'(vcfg.data);
        mtx[row][col + 1] = fix_t'(vcfg.data >> DATA_W);
      end
    end
    pending = expected_q.size();
  end

  initial begin
    fails   = 0;
    pending = 0;
  end

endmodule

FILE: tb/sv/tb_vertex_transform_perspective_divide_core.sv
// tb_vertex_transform_perspective_divide_core: stimulus, configuration and verdict for the core
// depends on vtpd_pkg, vtpd_if, the core and vtpd_tb_checker
`timescale 1ns / 1ps

module tb_vertex_transform_perspective_divide_core;
  import vtpd_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   no_idle;

  vtpd_in_if  vin();
  vtpd_out_if vout();
  vtpd_cfg_if vcfg();

  vertex_transform_perspective_divide_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_in (vin),
    .vtx_out(vout),
    .cfg_wr (vcfg)
  );

  vtpd_tb_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vin         (vin),
    .vout        (vout),
    .vcfg        (vcfg),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic fix_t pick_fix();
    case ($urandom_range(0, 4))
      0: pick_fix = fix_t'($urandom);
      1: pick_fix = fix_t'($urandom_range(0, 8 << FRAC_BITS)) - (fix_t'(4) <<< FRAC_BITS);
      2: pick_fix = fix_t'($urandom_range(0, 512)) - 256;
      3: pick_fix = fix_t'($urandom_range(0, 1 << 24)) - (fix_t'(1) <<< 23);
      default: begin
        case ($urandom_range(0, 4))
          0: pick_fix = FIX_MAX;
          1: pick_fix = FIX_MIN;
          2: pick_fix = '0;
          3: pick_fix = ONE_Q;
          default: pick_fix = -ONE_Q;
        endcase
      end
    endcase
  endfunction

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 2) @(negedge clk_i);
  endtask

  task automatic send_vertex(input action_e act, input fix_t x, input fix_t y, input fix_t z,
                             input fix_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      vin.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vin.valid  = 1'b1;
    vin.action = act;
    vin.in_x   = x;
    vin.in_y   = y;
    vin.in_z   = z;
    vin.in_w   = w;
    do @(posedge clk_i); while (!vin.ready);
    @(negedge clk_i);
  endtask

  task automatic write_row_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    vcfg.valid = 1'b1;
    vcfg.index = idx;
    vcfg.data  = val;
    do @(posedge clk_i); while (!vcfg.ready);
    @(negedge clk_i);
    vcfg.valid = 1'b0;
  endtask

  // kind 0 random, 1 moderate, 2 extremes, 3 zero matrix, 4 identity
  task automatic load_matrix(input int kind);
    logic [CFG_W-1:0] val;
    fix_t             lo;
    fix_t             hi;
    vin.valid = 1'b0;
    wait_drained();
    for (int i = 0; i < NREG; i++) begin
      case (kind)
        0: val = {$urandom, $urandom};
        1: begin
          lo  = fix_t'($urandom_range(0, 4 << FRAC_BITS)) - (fix_t'(2) <<< FRAC_BITS);
          hi  = fix_t'($urandom_range(0, 4 << FRAC_BITS)) - (fix_t'(2) <<< FRAC_BITS);
          val = {hi, lo};
        end
        2: val = $urandom_range(0, 1) ? {FIX_MAX, FIX_MIN} : {FIX_MIN, FIX_MAX};
        3: val = '0;
        default: val = cfg_reset(i);
      endcase
      write_row_reg(IDX_W'(i), val);
    end
    write_row_reg(IDX_W'(NREG + $urandom_range(0, NREG - 1)), {$urandom, $urandom});
  endtask

  initial begin
    vout.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int stall;
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        vout.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      vout.ready = 1'b1;
      do @(posedge clk_i); while (!vout.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    fix_t ext[5];
    ext = '{FIX_MAX, FIX_MIN, 0, ONE_Q, -ONE_Q};
    rst_ni     = 1'b0;
    no_idle    = 1'b0;
    vin.valid  = 1'b0;
    vin.action = ACT_POINT;
    vin.in_x   = '0;
    vin.in_y   = '0;
    vin.in_z   = '0;
    vin.in_w   = '0;
    vcfg.valid = 1'b0;
    vcfg.index = '0;
    vcfg.data  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // identity after reset
    for (int i = 0; i < 5; i++) begin
      send_vertex(ACT_POINT, ext[i], ext[4 - i], ext[(i + 2) % 5], ext[i]);
      send_vertex(ACT_VECTOR, ext[i], ext[(i + 1) % 5], ext[4 - i], ext[(i + 3) % 5]);
    end
    send_vertex(ACT_VECTOR, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
    // zero matrix: computed w of zero falls back to one
    load_matrix(3);
    send_vertex(ACT_POINT, FIX_MAX, FIX_MIN, ONE_Q, '0);
    send_vertex(ACT_VECTOR, FIX_MAX, FIX_MIN, ONE_Q, FIX_MAX);
    // extremes: saturation in both modes, negative and tiny divisors
    load_matrix(2);
    for (int i = 0; i < 5; i++) begin
      send_vertex(ACT_POINT, ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], ext[i]);
      send_vertex(ACT_VECTOR, ext[i], ext[(i + 4) % 5], ext[(i + 2) % 5], ext[(i + 3) % 5]);
    end

    for (int ph = 0; ph < 10; ph++) begin
      load_matrix(ph == 9 ? 4 : (ph % 3 == 2 ? 2 : ph % 2));
      no_idle = (ph % 4 == 3);
      for (int n = 0; n < 125; n++) begin
        if (ph == 5 && n == 60) begin
          vin.valid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        send_vertex($urandom_range(0, 1) ? ACT_VECTOR : ACT_POINT, pick_fix(), pick_fix(),
                    pick_fix(), pick_fix());
      end
    end
    vin.valid = 1'b0;
    no_idle   = 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: vertex_transform_perspective_divide_core.f
rtl/core/vtpd_pkg.sv
rtl/core/vtpd_if.sv
rtl/core/vtpd_row.sv
rtl/core/vtpd_div.sv
rtl/core/vertex_transform_perspective_divide_core.sv
rtl/core/vtpd_checker.sv
tb/sv/vtpd_tb_checker.sv
tb/sv/tb_vertex_transform_perspective_divide_core.sv
